// ===== src/sigmoid_cross_entropy_loss_top_assert.svh =====
// Assertion macros for the loss block. Clocked on clk_i, disabled in reset.
`ifndef SIGMOID_CROSS_ENTROPY_LOSS_TOP_ASSERT_SVH
`define SIGMOID_CROSS_ENTROPY_LOSS_TOP_ASSERT_SVH
`ifndef SYNTH
`define SCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sce assertion failed");
`define SCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sce assertion failed");
`else
`define SCE_ASSERT(lbl, prop)
`define SCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/sce_pkg.sv =====
`default_nettype none
package sce_pkg;

  localparam int MaxRowLength = 4096;
  localparam int CountW       = $clog2(MaxRowLength + 1);
  localparam int CfgW         = 13;
  localparam int LogitW       = 16;
  localparam int LabelW       = 16;
  localparam int LossW        = 24;
  localparam int SumW         = 40;
  localparam int AluW         = SumW + 2;
  localparam int ElemW        = 28;
  localparam int XzW          = 26;
  localparam int SpW          = 16;
  localparam int RomSize      = 256;
  localparam int RomIdxW      = $clog2(RomSize);
  localparam int DivCntW      = $clog2(SumW);

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [LossW-1:0]       LossMax = {LossW{1'b1}};

  localparam logic [63:0] Q30One  = 64'd1073741824;
  localparam logic [63:0] ExpStep = 64'd1008687096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SP,
    S_SUB_XZ,
    S_ACC,
    S_DIV,
    S_EMIT
  } sce_state_e;

  typedef struct packed {
    logic signed [AluW-1:0] a;
    logic signed [AluW-1:0] b;
    logic                   sub;
  } sce_alu_req_t;

  typedef logic [RomSize-1:0][SpW-1:0] sp_rom_t;

  // long division by shift and subtract, quotient known to fit qbits
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d, int qbits);
    logic [63:0] r;
    logic [63:0] q;
    r = n;
    q = '0;
    for (int i = qbits - 1; i >= 0; i--) begin
      if (r >= (d << i)) begin
        r    = r - (d << i);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1+exp(-i/16)) in Q.16 via 2*atanh(e/(2+e)), Q.30 internally
  function automatic sp_rom_t build_rom();
    sp_rom_t     rom;
    logic [63:0] e;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] pw;
    logic [63:0] acc;
    e = Q30One;
    for (int i = 0; i < RomSize; i++) begin
      y   = udiv(e << 30, (Q30One << 1) + e, 31);
      y2  = (y * y) >> 30;
      pw  = y;
      acc = '0;
      for (int k = 1; k <= 25; k += 2) begin
        acc = acc + udiv(pw, 64'(k), 31);
        pw  = (pw * y2) >> 30;
      end
      acc    = acc << 1;
      rom[i] = SpW'((acc + 64'd8192) >> 14);
      e      = (e * ExpStep + (Q30One >> 1)) >> 30;
    end
    return rom;
  endfunction

  localparam sp_rom_t SpRom = build_rom();

endpackage
`default_nettype wire

// ===== src/sce_in_if.sv =====
`default_nettype none
interface sce_in_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [sce_pkg::LogitW-1:0]    logit;
  logic        [sce_pkg::LabelW-1:0]    label;

  modport source (output valid, output logit, output label, input ready);
  modport sink   (input valid, input logit, input label, output ready);
endinterface
`default_nettype wire

// ===== src/sce_out_if.sv =====
`default_nettype none
interface sce_out_if ();
  logic                          valid;
  logic                          ready;
  logic [sce_pkg::LossW-1:0]     row_loss;

  modport source (output valid, output row_loss, input ready);
  modport sink   (input valid, input row_loss, output ready);
endinterface
`default_nettype wire

// ===== src/sigmoid_cross_entropy_loss_top.sv =====
// Sigmoid cross-entropy loss, averaged per row. Each request carries a Q8.8
// logit and a Q1.15 label; row_length requests form a row, and at its end one
// Q8.16 mean loss (truncated, saturated at all ones, zero for a negative sum)
// is sent. All arithmetic goes through one 42-bit adder under a sequencer:
// an element passes accept, add softplus, subtract x*z and accumulate, and
// the last element of a row then takes 40 restoring division steps on the
// same adder and a load of the output register, or only that load when the
// row sum is negative and the division is skipped. The output register
// lets the next row start while a result waits; a row that ends while the
// previous result is still held waits in its last step. The row length is
// sampled as written; 0 acts as 1 and values above 4096 act as 4096.
`default_nettype none
`include "sigmoid_cross_entropy_loss_top_assert.svh"
module sigmoid_cross_entropy_loss_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [sce_pkg::CfgW-1:0]  cfg_data_i,
  sce_in_if.sink                         in_i,
  sce_out_if.source                      out_o
);

  sce_pkg::sce_state_e state_q, state_d;

  logic [sce_pkg::CfgW-1:0]          row_len_q;
  logic [sce_pkg::CountW-1:0]        eff_len;
  logic [sce_pkg::CountW-1:0]        count_q, count_d;
  logic signed [sce_pkg::SumW-1:0]   sum_q, sum_d;
  logic [sce_pkg::CountW-1:0]        rem_q, rem_d;
  logic [sce_pkg::DivCntW-1:0]       div_cnt_q, div_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [sce_pkg::LossW-1:0]         out_data_q, out_data_d;

  logic signed [sce_pkg::ElemW-1:0]  elem_q, elem_d;
  logic [sce_pkg::SpW-1:0]           sp_q, sp_d;
  logic signed [sce_pkg::XzW-1:0]    xz_q, xz_d;

  sce_pkg::sce_alu_req_t             alu_req;
  logic signed [sce_pkg::AluW-1:0]   alu_y;

  logic                              in_fire;
  logic                              emit_ok;
  logic signed [sce_pkg::LogitW-1:0] x;
  logic [sce_pkg::LogitW:0]          ax;
  logic signed [32:0]                prod;
  logic signed [sce_pkg::SumW-1:0]   sum_sat;
  logic [sce_pkg::CountW-1:0]        count_inc;
  logic                              row_end;
  logic [sce_pkg::CountW:0]          div_trial;

  sce_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  always_comb begin
    if (row_len_q == '0) begin
      eff_len = sce_pkg::CountW'(1);
    end else if (32'(row_len_q) > sce_pkg::MaxRowLength) begin
      eff_len = sce_pkg::CountW'(sce_pkg::MaxRowLength);
    end else begin
      eff_len = sce_pkg::CountW'(row_len_q);
    end
  end

  assign in_fire = in_i.valid && in_i.ready;
  assign emit_ok = !out_valid_q || out_o.ready;

  // element terms, formed while the request is taken
  assign x    = in_i.logit;
  assign ax   = x[sce_pkg::LogitW-1] ? ((sce_pkg::LogitW+1)'(0) - {1'b1, x}) : {1'b0, x};
  assign prod = x * $signed({1'b0, in_i.label});

  always_comb begin
    elem_d = (!x[sce_pkg::LogitW-1] && (x != '0))
             ? sce_pkg::ElemW'($signed({x, 8'h00})) : '0;
    sp_d   = (ax[sce_pkg::LogitW:12] == '0) ? sce_pkg::SpRom[ax[11:4]] : '0;
    xz_d   = prod[32:7];
  end

  // accumulator saturation and row bookkeeping
  always_comb begin
    if (alu_y[sce_pkg::AluW-1:sce_pkg::SumW-1] == '0 ||
        alu_y[sce_pkg::AluW-1:sce_pkg::SumW-1] == '1) begin
      sum_sat = alu_y[sce_pkg::SumW-1:0];
    end else if (alu_y[sce_pkg::AluW-1]) begin
      sum_sat = sce_pkg::SumMin;
    end else begin
      sum_sat = sce_pkg::SumMax;
    end
    count_inc = count_q + sce_pkg::CountW'(1);
    row_end   = count_inc >= eff_len;
    div_trial = alu_y[sce_pkg::CountW:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sce_pkg::S_IDLE:   if (in_fire) state_d = sce_pkg::S_ADD_SP;
      sce_pkg::S_ADD_SP: state_d = sce_pkg::S_SUB_XZ;
      sce_pkg::S_SUB_XZ: state_d = sce_pkg::S_ACC;
      sce_pkg::S_ACC: begin
        if (!row_end) begin
          state_d = sce_pkg::S_IDLE;
        end else if (sum_sat < 0) begin
          state_d = sce_pkg::S_EMIT;
        end else begin
          state_d = sce_pkg::S_DIV;
        end
      end
      sce_pkg::S_DIV:    if (32'(div_cnt_q) == sce_pkg::SumW - 1) state_d = sce_pkg::S_EMIT;
      sce_pkg::S_EMIT:   if (emit_ok) state_d = sce_pkg::S_IDLE;
      default:           state_d = sce_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_i.ready  = 1'b0;
    alu_req     = '0;
    count_d     = count_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    unique case (state_q)
      sce_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
      end
      sce_pkg::S_ADD_SP: begin
        alu_req.a = sce_pkg::AluW'(elem_q);
        alu_req.b = sce_pkg::AluW'({1'b0, sp_q});
      end
      sce_pkg::S_SUB_XZ: begin
        alu_req.a   = sce_pkg::AluW'(elem_q);
        alu_req.b   = sce_pkg::AluW'(xz_q);
        alu_req.sub = 1'b1;
      end
      sce_pkg::S_ACC: begin
        alu_req.a = sce_pkg::AluW'(sum_q);
        alu_req.b = sce_pkg::AluW'(elem_q);
        if (!row_end) begin
          sum_d   = sum_sat;
          count_d = count_inc;
        end else begin
          count_d   = '0;
          rem_d     = '0;
          div_cnt_d = '0;
          sum_d     = (sum_sat < 0) ? '0 : sum_sat;
        end
      end
      sce_pkg::S_DIV: begin
        // restoring step: the dividend shifts out of sum_q, quotient bits shift in
        alu_req.a   = sce_pkg::AluW'({rem_q, sum_q[sce_pkg::SumW-1]});
        alu_req.b   = sce_pkg::AluW'(eff_len);
        alu_req.sub = 1'b1;
        if (!alu_y[sce_pkg::AluW-1]) begin
          rem_d = div_trial[sce_pkg::CountW-1:0];
          sum_d = {sum_q[sce_pkg::SumW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[sce_pkg::CountW-2:0], sum_q[sce_pkg::SumW-1]};
          sum_d = {sum_q[sce_pkg::SumW-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + sce_pkg::DivCntW'(1);
      end
      sce_pkg::S_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_data_d  = (sum_q[sce_pkg::SumW-1:sce_pkg::LossW] != '0)
                        ? sce_pkg::LossMax : sum_q[sce_pkg::LossW-1:0];
          sum_d       = '0;
        end
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sce_pkg::S_IDLE;
      row_len_q   <= sce_pkg::CfgW'(1);
      count_q     <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      rem_q       <= rem_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) row_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_fire) begin
      sp_q <= sp_d;
      xz_q <= xz_d;
    end
    unique case (state_q)
      sce_pkg::S_IDLE:   if (in_fire) elem_q <= elem_d;
      sce_pkg::S_ADD_SP: elem_q <= alu_y[sce_pkg::ElemW-1:0];
      sce_pkg::S_SUB_XZ: elem_q <= alu_y[sce_pkg::ElemW-1:0];
      default:           elem_q <= elem_q;
    endcase
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.row_loss = out_data_q;

  `SCE_ASSERT_NEXT(a_accept_starts_work, in_fire, state_q == sce_pkg::S_ADD_SP)
  `SCE_ASSERT(a_count_below_len, (state_q != sce_pkg::S_ACC) || (count_q <= 13'(sce_pkg::MaxRowLength)))
  `SCE_ASSERT(a_rem_below_len, (state_q != sce_pkg::S_DIV) || (rem_q < eff_len))
  `SCE_ASSERT_NEXT(a_emit_loads_out, (state_q == sce_pkg::S_EMIT) && emit_ok, out_valid_q && (state_q == sce_pkg::S_IDLE))

endmodule
`default_nettype wire

// ===== src/sce_alu.sv =====
`default_nettype none
module sce_alu (
  input  sce_pkg::sce_alu_req_t             req_i,
  output logic signed [sce_pkg::AluW-1:0]   y_o
);

  assign y_o = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

endmodule
`default_nettype wire
